/* src/i2cms_pkg.sv */
// Shared types and constants for the I2C master pin sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_WRITE    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;
  localparam logic [2:0] OP_WAIT_ACK = 3'd5;

  // Phase code of the idle sequencer.
  localparam logic [4:0] PH_IDLE = 5'd31;

  // Reset value of the acknowledge timeout register.
  localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

  // Register index of the acknowledge timeout limit.
  localparam logic REG_ACK_LIMIT = 1'b0;

  // One command item.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } i2cms_cmd_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } i2cms_res_t;

  // Driven pin state.
  typedef struct packed {
    logic en;
    logic sda;
    logic scl;
  } i2cms_pins_t;

  // Pin state after one step of the stop sequence, and its last-step flag.
  typedef struct packed {
    i2cms_pins_t pins;
    logic        done;
  } i2cms_stop_t;

  // One step of the stop sequence: drive SDA and drop SCL, SDA low, SCL high, SDA high.
  function automatic i2cms_stop_t stop_step(input logic [4:0] k, input i2cms_pins_t pins);
    i2cms_stop_t r;
    r.pins = pins;
    r.done = 1'b0;
    case (k)
      5'd0: begin
        r.pins.en  = 1'b1;
        r.pins.scl = 1'b0;
      end
      5'd1: r.pins.sda = 1'b0;
      5'd2: r.pins.scl = 1'b1;
      default: begin
        r.pins.sda = 1'b1;
        r.done     = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

/* src/i2cms_core.sv */
// Sequencer state and the single-step pin logic of the I2C master.
`timescale 1ns / 1ps

module i2cms_core import i2cms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  i2cms_cmd_t cmd,
  input  logic [7:0] ack_timeout_limit,
  output i2cms_res_t res
);

  logic [4:0]  phase;
  logic [2:0]  active_command;
  logic [7:0]  shift_byte;
  logic [7:0]  wait_count;
  logic        ack_to_send;
  i2cms_pins_t pins;

  logic [4:0]  phase_next;
  logic [2:0]  active_command_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  wait_count_next;
  logic        ack_to_send_next;
  i2cms_pins_t pins_next;

  logic        load;
  logic [4:0]  phase_cur;
  logic [4:0]  phase_inc;
  logic [4:0]  wr_x;
  logic [8:0]  wr_prod;
  logic [2:0]  wr_bit;
  logic [4:0]  wr_sub;
  logic [2:0]  rd_bit;
  logic [7:0]  wait_inc;
  logic        done;
  logic        acked;
  i2cms_stop_t stop_r;

  // Accept a command only while idle, then run its first step on the same item.
  always_comb begin
    load = (phase == PH_IDLE) && (cmd.op >= OP_START) && (cmd.op <= OP_WAIT_ACK);

    active_command_next = load ? cmd.op : active_command;
    phase_cur           = load ? 5'd0 : phase;
    wait_count_next     = load ? 8'd0 : wait_count;
    ack_to_send_next    = (load && cmd.op == OP_READ) ? cmd.send_ack : ack_to_send;
    shift_byte_next     = shift_byte;
    if (load && cmd.op == OP_WRITE) begin
      shift_byte_next = cmd.write_byte;
    end else if (load && cmd.op == OP_READ) begin
      shift_byte_next = 8'd0;
    end

    pins_next  = pins;
    done       = 1'b0;
    acked      = 1'b0;
    phase_inc  = phase_cur + 5'd1;

    // Write phases after the first: bit = (phase - 1) / 3 by reciprocal, sub = remainder.
    wr_x    = phase_cur - 5'd1;
    wr_prod = {4'd0, wr_x} * 9'd11;
    wr_bit  = wr_prod[7:5];
    wr_sub  = wr_x - ({2'd0, wr_bit} + {1'b0, wr_bit, 1'b0});

    rd_bit   = phase_cur[3:1];
    wait_inc = wait_count_next + 8'd1;
    stop_r   = stop_step(phase_cur, pins);

    if (phase_cur != PH_IDLE) begin
      unique case (active_command_next)
        OP_START: begin
          if (phase_cur == 5'd0) begin
            pins_next.en  = 1'b1;
            pins_next.scl = 1'b1;
          end else if (phase_cur == 5'd1) begin
            pins_next.sda = 1'b1;
          end else if (phase_cur == 5'd2) begin
            pins_next.sda = 1'b0;
          end else begin
            pins_next.scl = 1'b0;
            done          = 1'b1;
          end
        end
        OP_STOP: begin
          pins_next = stop_r.pins;
          done      = stop_r.done;
        end
        OP_WRITE: begin
          if (phase_cur == 5'd0) begin
            pins_next.en  = 1'b1;
            pins_next.scl = 1'b0;
          end else if (wr_sub[1:0] == 2'd0) begin
            pins_next.sda = shift_byte_next[3'd7 - wr_bit];
          end else if (wr_sub[1:0] == 2'd1) begin
            pins_next.scl = 1'b1;
          end else begin
            pins_next.scl = 1'b0;
            done          = (wr_bit == 3'd7);
          end
        end
        OP_READ: begin
          if (phase_cur < 5'd16) begin
            if (!phase_cur[0]) begin
              pins_next.en  = 1'b0;
              pins_next.sda = 1'b1;
              pins_next.scl = 1'b0;
            end else begin
              pins_next.scl                 = 1'b1;
              shift_byte_next[3'd7 - rd_bit] = cmd.sda_in;
            end
          end else if (phase_cur == 5'd16) begin
            pins_next.scl = 1'b0;
          end else if (phase_cur == 5'd17) begin
            pins_next.en  = 1'b1;
            pins_next.sda = !ack_to_send_next;
          end else if (phase_cur == 5'd18) begin
            pins_next.scl = 1'b1;
          end else begin
            pins_next.scl = 1'b0;
            done          = 1'b1;
          end
        end
        default: begin
          // Acknowledge wait: sample with SCL high, fall into the stop sequence on timeout.
          if (phase_cur <= 5'd1) begin
            if (phase_cur == 5'd0) begin
              pins_next.en  = 1'b0;
              pins_next.sda = 1'b1;
              pins_next.scl = 1'b1;
            end
            if (!cmd.sda_in) begin
              phase_inc = 5'd2;
            end else begin
              wait_count_next = wait_inc;
              phase_inc       = (wait_inc > ack_timeout_limit) ? 5'd3 : 5'd1;
            end
          end else if (phase_cur == 5'd2) begin
            pins_next.scl = 1'b0;
            done          = 1'b1;
            acked         = 1'b1;
          end else begin
            stop_r    = stop_step(phase_cur - 5'd3, pins);
            pins_next = stop_r.pins;
            done      = stop_r.done;
          end
        end
      endcase
    end

    phase_next = (phase_cur == PH_IDLE || done) ? PH_IDLE : phase_inc;
  end

  // Result of this step.
  always_comb begin
    res.scl_level        = pins_next.scl;
    res.sda_level        = pins_next.sda;
    res.sda_drive_enable = pins_next.en;
    res.busy_res         = (phase_next != PH_IDLE);
    res.done_res         = done;
    res.read_data        = shift_byte_next;
    res.ack_seen         = acked;
  end

  // Sequencer state advances once per stepped item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_command <= OP_NONE;
      shift_byte     <= 8'd0;
      wait_count     <= 8'd0;
      ack_to_send    <= 1'b0;
      pins           <= '{en: 1'b1, sda: 1'b1, scl: 1'b1};
    end else if (step) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      shift_byte     <= shift_byte_next;
      wait_count     <= wait_count_next;
      ack_to_send    <= ack_to_send_next;
      pins           <= pins_next;
    end
  end

endmodule

/* src/i2c_master_pin_sequencer_unit.sv */
// Top level of the I2C master pin sequencer: item pipeline and register port.
//
//   channel  direction  handshake             payload
//   cmd      in         cmd_valid/cmd_stall   i2cms_cmd_t (op, write_byte, send_ack, sda_in)
//   res      out        res_valid/res_stall   i2cms_res_t (pins, busy, done, read_data, ack)
//   apb      in/out     psel/penable/pready   ack_timeout_limit at byte address 0
//
// An item is accepted into an input register, takes one pin step of the sequencer into the
// result register when both stages advance, and its result is then offered on res.
// One item is accepted every cycle unless the result side stalls with the input register full.
// Reset is synchronous and returns the sequencer to idle with SCL high and SDA driven high.
// A stall on the result side holds both stages; an empty input register still takes an item
// while the result register waits.
`timescale 1ns / 1ps

module i2c_master_pin_sequencer_unit import i2cms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  i2cms_cmd_t  cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output i2cms_res_t  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_valid;
  i2cms_cmd_t in_cmd;
  logic       advance;
  logic       cmd_take;
  logic [7:0] ack_timeout_limit;
  i2cms_res_t step_res;

  // Both stages move when the result register is empty or being taken.
  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = in_valid && !advance;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance || !in_valid) begin
      in_valid <= cmd_take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      in_cmd <= cmd;
    end
  end

  // Sequencer steps once for each item leaving the input register.
  i2cms_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (in_valid && advance),
    .cmd               (in_cmd),
    .ack_timeout_limit (ack_timeout_limit),
    .res               (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res <= step_res;
    end
  end

  // Register port: one register, selected by the word address bit.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACK_LIMIT) ? {24'd0, ack_timeout_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_limit <= ACK_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACK_LIMIT) begin
      ack_timeout_limit <= pwdata[7:0];
    end
  end

`ifndef SYNTH
  // A finished command never reports the sequence as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.done_res && res.busy_res))
    else $error("result shows done and busy together");

  // An acknowledge is reported only on the finishing item.
  a_ack_with_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.ack_seen) |-> res.done_res)
    else $error("ack_seen without done");

  // A register write is visible on the read port in the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == REG_ACK_LIMIT) |=>
      (prdata[7:0] == $past(pwdata[7:0]) || paddr[2] != REG_ACK_LIMIT))
    else $error("timeout limit write lost");

  // A stepped item always lands in the result register.
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> res_valid)
    else $error("stepped item did not reach the result register");
`endif

endmodule
